@@ design/assert_macros.svh @@
// Assertion macros shared by the ordered list engine modules.
// The using module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ole_pkg.sv @@
// Package for the ordered list engine: item structs, operation and status codes,
// and the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package ole_pkg;

  // operation codes
  localparam logic [2:0] FN_APPEND = 3'd0;
  localparam logic [2:0] FN_INSERT = 3'd1;
  localparam logic [2:0] FN_RM_VAL = 3'd2;
  localparam logic [2:0] FN_RM_AT  = 3'd3;
  localparam logic [2:0] FN_SEARCH = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
    logic [15:0]        position;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [5:0] found_index;
    logic [6:0] count;
  } out_item_t;

  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_SCAN_INIT,
    STEP_SCAN,
    STEP_DN_INIT,
    STEP_DN,
    STEP_UP_INIT,
    STEP_UP
  } step_t;

  typedef enum logic [1:0] {
    ADJ_NONE,
    ADJ_INC,
    ADJ_DEC
  } adj_t;

  typedef struct packed {
    logic       load;
    step_t      step;
    logic       finish;
    logic [1:0] status;
    logic       found;
    adj_t       adj;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       full;
    logic       oor;
    logic       empty;
    logic       hit;
    logic       last;
    logic       dn_done;
    logic       up_done;
    logic       out_free;
  } dp_sts_t;

endpackage

@@ design/ordered_list_engine.sv @@
// Ordered list engine: an ordered list of signed values in one entry memory,
// with append, insert, remove by value or position, and search.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one request item
//   (func, value, position). Result channel out_valid/out_ready/out_data
//   returns exactly one item per request (status, found, found_index, count).
//   Requests are handled one at a time. The memory has one read and one write
//   port and every scan or shift step visits one entry per cycle. An append
//   writes at the end, insert at p shifts the entries from p up, remove-at p
//   shifts the entries above p down, search scans from index 0 up to the hit,
//   and remove-value scans and then shifts down as remove-at does.
//   A finished result sits in an output register; the next request is taken
//   while it waits. If the receiver stalls, the following request completes
//   its work and then holds until the output register frees up.
//   Reset (rst_n low, synchronous) empties the list; memory contents are not
//   cleared and no clearing pass is needed.
// Depends on ole_pkg, ole_ctrl, ole_dp.
`timescale 1ns / 1ps

module ordered_list_engine #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ole_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ole_pkg::out_item_t out_data
);
  import ole_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ole_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ole_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ design/ole_dp.sv @@
// Datapath of the ordered list engine: entry memory, count, scan and shift
// address logic, and the result register. Uses ole_pkg and assert_macros.svh.
`timescale 1ns / 1ps

module ole_dp #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ole_pkg::in_item_t  in_data,
  input  ole_pkg::dp_cmd_t   cmd,
  output ole_pkg::dp_sts_t   sts,
  output logic               out_valid,
  input  logic               out_ready,
  output ole_pkg::out_item_t out_data
);
  import ole_pkg::*;
  `include "assert_macros.svh"

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  logic [2:0]            func_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [CW-1:0]         pos_r;
  logic                  oor_r;
  logic [CW-1:0]         cnt_r;
  logic [CW-1:0]         cnt_nxt;
  logic [CW-1:0]         idx_r;
  logic                  chk_vld_r;
  logic [CW-1:0]         chk_idx_r;
  logic                  mv_vld_r;
  logic [AW-1:0]         mv_addr_r;
  logic [DATA_WIDTH-1:0] rd_data_r;
  out_item_t             out_r;
  logic                  out_valid_r;

  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [63:0]           val_ext;
  logic                  clamp;
  logic                  idx_lt_cnt;
  logic                  idx_gt_pos;

  // sign-extend to 64 bits, keep the low DATA_WIDTH bits
  assign val_ext = {{32{in_data.value[31]}}, in_data.value};
  assign clamp   = (in_data.func == FN_APPEND) ||
                   (32'(in_data.position) > 32'(cnt_r));

  assign idx_lt_cnt = idx_r < cnt_r;
  assign idx_gt_pos = idx_r > pos_r;

  always_comb begin
    sts.func     = func_r;
    sts.full     = cnt_r == CW'(CAPACITY);
    sts.oor      = oor_r;
    sts.empty    = cnt_r == '0;
    sts.hit      = chk_vld_r && (rd_data_r == val_r);
    sts.last     = chk_vld_r && (chk_idx_r == cnt_r - CW'(1));
    sts.dn_done  = !idx_lt_cnt && !mv_vld_r;
    sts.up_done  = (idx_r == pos_r) && !mv_vld_r;
    sts.out_free = !out_valid_r || out_ready;
  end

  always_comb begin
    unique case (cmd.adj)
      ADJ_INC: cnt_nxt = cnt_r + CW'(1);
      ADJ_DEC: cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = mv_addr_r;
    wr_data = rd_data_r;
    unique case (cmd.step)
      STEP_SCAN: begin
        rd_en   = idx_lt_cnt;
        rd_addr = idx_r[AW-1:0];
      end
      STEP_DN: begin
        rd_en   = idx_lt_cnt;
        rd_addr = idx_r[AW-1:0];
        wr_en   = mv_vld_r;
      end
      STEP_UP: begin
        rd_en   = idx_gt_pos;
        rd_addr = AW'(idx_r - CW'(1));
        if (mv_vld_r) begin
          wr_en = 1'b1;
        end else if (idx_r == pos_r) begin
          // shifting finished: drop the new value into the gap
          wr_en   = 1'b1;
          wr_addr = pos_r[AW-1:0];
          wr_data = val_r;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // item capture, scan and shift pointers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_data.func;
      val_r  <= val_ext[DATA_WIDTH-1:0];
      pos_r  <= clamp ? cnt_r : in_data.position[CW-1:0];
      oor_r  <= 32'(in_data.position) >= 32'(cnt_r);
    end
    unique case (cmd.step)
      STEP_SCAN_INIT: begin
        idx_r <= '0;
      end
      STEP_SCAN: begin
        if (idx_lt_cnt) begin
          idx_r <= idx_r + CW'(1);
        end
        chk_idx_r <= idx_r;
        if (sts.hit) begin
          pos_r <= chk_idx_r;
        end
      end
      STEP_DN_INIT: begin
        idx_r <= pos_r + CW'(1);
      end
      STEP_DN: begin
        mv_addr_r <= AW'(idx_r - CW'(1));
        if (idx_lt_cnt) begin
          idx_r <= idx_r + CW'(1);
        end
      end
      STEP_UP_INIT: begin
        idx_r <= cnt_r;
      end
      STEP_UP: begin
        mv_addr_r <= idx_r[AW-1:0];
        if (idx_gt_pos) begin
          idx_r <= idx_r - CW'(1);
        end
      end
      default: begin
        idx_r <= idx_r;
      end
    endcase
    if (cmd.finish) begin
      out_r.status      <= cmd.status;
      out_r.found       <= cmd.found;
      out_r.found_index <= cmd.found ? 6'(pos_r) : 6'd0;
      out_r.count       <= 7'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      mv_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        cnt_r <= cnt_nxt;
      end
      unique case (cmd.step)
        STEP_SCAN_INIT: chk_vld_r <= 1'b0;
        STEP_SCAN:      chk_vld_r <= idx_lt_cnt;
        STEP_DN_INIT:   mv_vld_r  <= 1'b0;
        STEP_DN:        mv_vld_r  <= idx_lt_cnt;
        STEP_UP_INIT:   mv_vld_r  <= 1'b0;
        STEP_UP:        mv_vld_r  <= idx_gt_pos;
        default:        mv_vld_r  <= mv_vld_r;
      endcase
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `OLE_ASSERT_IMP(a_cnt_bound, 1'b1, 32'(cnt_r) <= CAPACITY, "entry count above capacity")
  `OLE_ASSERT_IMP(a_wr_range, wr_en, 32'(wr_addr) < CAPACITY, "memory write out of range")

endmodule

@@ design/ole_ctrl.sv @@
// Controller of the ordered list engine: sequences decode, scan and shift
// steps through the datapath. Uses ole_pkg and assert_macros.svh.
`timescale 1ns / 1ps

module ole_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ole_pkg::dp_sts_t sts,
  output ole_pkg::dp_cmd_t cmd
);
  import ole_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_DN_INIT,
    S_DN,
    S_UP,
    S_DONE
  } state_t;

  state_t     state_r;
  logic [1:0] res_status_r;
  logic       res_found_r;
  adj_t       res_adj_r;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    cmd.load   = 1'b0;
    cmd.step   = STEP_NONE;
    cmd.finish = 1'b0;
    cmd.status = res_status_r;
    cmd.found  = res_found_r;
    cmd.adj    = res_adj_r;
    unique case (state_r)
      S_IDLE: cmd.load = in_valid;
      S_DECODE: begin
        if ((sts.func == FN_APPEND || sts.func == FN_INSERT) && !sts.full) begin
          cmd.step = STEP_UP_INIT;
        end else if ((sts.func == FN_RM_VAL || sts.func == FN_SEARCH) && !sts.empty) begin
          cmd.step = STEP_SCAN_INIT;
        end
      end
      S_SCAN:    cmd.step = STEP_SCAN;
      S_DN_INIT: cmd.step = STEP_DN_INIT;
      S_DN:      cmd.step = STEP_DN;
      S_UP:      cmd.step = STEP_UP;
      S_DONE:    cmd.finish = sts.out_free;
      default:   cmd.step = STEP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      res_status_r <= ST_OK;
      res_found_r  <= 1'b0;
      res_adj_r    <= ADJ_NONE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_status_r <= ST_OK;
          res_found_r  <= 1'b0;
          res_adj_r    <= ADJ_NONE;
          priority if (sts.func == FN_APPEND || sts.func == FN_INSERT) begin
            if (sts.full) begin
              res_status_r <= ST_FULL;
              state_r      <= S_DONE;
            end else begin
              state_r <= S_UP;
            end
          end else if (sts.func == FN_RM_VAL) begin
            if (sts.empty) begin
              res_status_r <= ST_NOTFOUND;
              state_r      <= S_DONE;
            end else begin
              state_r <= S_SCAN;
            end
          end else if (sts.func == FN_SEARCH) begin
            state_r <= sts.empty ? S_DONE : S_SCAN;
          end else if (sts.func == FN_RM_AT) begin
            if (sts.oor) begin
              res_status_r <= ST_RANGE;
              state_r      <= S_DONE;
            end else begin
              state_r <= S_DN_INIT;
            end
          end else begin
            state_r <= S_DONE;
          end
        end
        S_SCAN: begin
          // a hit wins over running off the end on the same entry
          if (sts.hit) begin
            if (sts.func == FN_SEARCH) begin
              res_found_r <= 1'b1;
              state_r     <= S_DONE;
            end else begin
              state_r <= S_DN_INIT;
            end
          end else if (sts.last) begin
            res_status_r <= (sts.func == FN_RM_VAL) ? ST_NOTFOUND : ST_OK;
            state_r      <= S_DONE;
          end
        end
        S_DN_INIT: state_r <= S_DN;
        S_DN: begin
          if (sts.dn_done) begin
            res_adj_r <= ADJ_DEC;
            state_r   <= S_DONE;
          end
        end
        S_UP: begin
          if (sts.up_done) begin
            res_adj_r <= ADJ_INC;
            state_r   <= S_DONE;
          end
        end
        S_DONE: begin
          if (sts.out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `OLE_ASSERT_IMP(a_finish_free, cmd.finish, sts.out_free, "result written over a held item")
  `OLE_ASSERT_NXT(a_full_no_shift,
    state_r == S_DECODE && sts.full && (sts.func == FN_APPEND || sts.func == FN_INSERT),
    state_r == S_DONE, "add to a full list did not go straight to result")

endmodule

@@ verif/tb_ordered_list_engine.sv @@
// Self-checking testbench for ordered_list_engine: directed and random requests,
// with results checked against a list model kept in the bench.
// Depends on ole_pkg and the ordered_list_engine RTL.
`timescale 1ns / 1ps

module tb_ordered_list_engine;
  import ole_pkg::*;

  localparam int LIST_CAP   = 64;
  localparam int LONG_HOLD  = 400;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_WAIT = 100;
  localparam int MAX_PRINTS = 40;

  // func codes the block ignores
  localparam logic [2:0] FN_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] FN_UNUSED_LAST  = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  ordered_list_engine u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // list model
  logic signed [31:0] list_vals [LIST_CAP];
  int                 list_len = 0;

  in_item_t  pending_reqs[$];
  out_item_t expected_results[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int err_count = 0;
  int idle_cycles = 0;

  // stimulus shaping
  int est_len = 0;
  int len_goal = 0;
  logic signed [31:0] value_pool [12] = '{
    32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1, 32'sd1, 32'sd7, 32'sd42,
    -32'sd100, 32'sd1000, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sd12345
  };

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic int find_value(logic signed [31:0] v);
    int i;
    for (i = 0; i < list_len; i++) begin
      if (list_vals[i] == v) return i;
    end
    return -1;
  endfunction

  function automatic void drop_entry(int p);
    int i;
    for (i = p; i + 1 < list_len; i++) list_vals[i] = list_vals[i + 1];
    list_len--;
  endfunction

  // updates the list model and returns the result the block should give
  function automatic out_item_t apply_list_op(in_item_t req);
    out_item_t res;
    int        p;
    int        i;
    int        hit;
    res = '0;
    case (req.func)
      FN_APPEND, FN_INSERT: begin
        if (list_len >= LIST_CAP) begin
          res.status = ST_FULL;
        end else begin
          p = (req.func == FN_APPEND || req.position > list_len) ? list_len : req.position;
          for (i = list_len; i > p; i--) list_vals[i] = list_vals[i - 1];
          list_vals[p] = req.value;
          list_len++;
        end
      end
      FN_RM_VAL: begin
        hit = find_value(req.value);
        if (hit < 0) res.status = ST_NOTFOUND;
        else drop_entry(hit);
      end
      FN_RM_AT: begin
        if (req.position >= list_len) res.status = ST_RANGE;
        else drop_entry(req.position);
      end
      FN_SEARCH: begin
        hit = find_value(req.value);
        if (hit >= 0) begin
          res.found = 1'b1;
          res.found_index = 6'(hit);
        end
      end
      default: ;
    endcase
    res.count = 7'(list_len);
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(apply_list_op(in_data));
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver back-pressure
  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", out_data.status, want.status));
          if (out_data.found !== want.found)
            report_mismatch($sformatf("found got %0b want %0b", out_data.found, want.found));
          if (out_data.found_index !== want.found_index)
            report_mismatch($sformatf("found_index got %0d want %0d",
                                      out_data.found_index, want.found_index));
          if (out_data.count !== want.count)
            report_mismatch($sformatf("count got %0d want %0d", out_data.count, want.count));
        end
      end
      if (hold_ack != hold_req) begin
        hold_ack <= hold_req;
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog: no item moving on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic push_req(input logic [2:0] fn, input logic signed [31:0] v,
                          input logic [15:0] pos);
    in_item_t req;
    req.func = fn;
    req.value = v;
    req.position = pos;
    pending_reqs.push_back(req);
  endtask

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(99) < 70) return value_pool[$urandom_range(11)];
    return $urandom;
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    est_len = list_len;
  endtask

  // mostly well-formed traffic steered toward a drifting target length
  task automatic queue_random_requests(input int n);
    logic [2:0]  fn;
    logic [15:0] pos;
    int          r;
    int          k;
    bit          grow;
    for (k = 0; k < n; k++) begin
      if (k % 64 == 0) begin
        case ($urandom_range(3))
          0: len_goal = 0;
          1: len_goal = LIST_CAP;
          default: len_goal = $urandom_range(LIST_CAP);
        endcase
      end
      grow = (est_len < len_goal) || (len_goal == LIST_CAP);
      r = $urandom_range(99);
      if (r < 3) fn = 3'($urandom_range(FN_UNUSED_LAST, FN_UNUSED_FIRST));
      else if (grow) fn = (r < 50) ? FN_APPEND : (r < 75) ? FN_INSERT :
                          (r < 85) ? FN_SEARCH : (r < 92) ? FN_RM_VAL : FN_RM_AT;
      else fn = (r < 12) ? FN_APPEND : (r < 22) ? FN_INSERT :
                (r < 45) ? FN_RM_VAL : (r < 70) ? FN_RM_AT : FN_SEARCH;
      r = $urandom_range(99);
      if (r < 8) pos = '0;
      else if (r < 16) pos = 16'($urandom);
      else pos = 16'($urandom_range(est_len + 2));
      push_req(fn, pick_value(), pos);
      case (fn)
        FN_APPEND, FN_INSERT: if (est_len < LIST_CAP) est_len++;
        FN_RM_VAL: if (est_len > 0) est_len--;
        FN_RM_AT: if (pos < est_len) est_len--;
        default: ;
      endcase
    end
  endtask

  initial begin : stimulus
    int k;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty list cases, extremes, clamping, duplicates, tail removal
    push_req(FN_SEARCH, 32'sd0, 16'd0);
    push_req(FN_RM_VAL, 32'sd0, 16'd0);
    push_req(FN_RM_AT, 32'sd0, 16'd0);
    push_req(FN_APPEND, 32'sh8000_0000, 16'hffff);
    push_req(FN_APPEND, 32'sh7fff_ffff, 16'd0);
    push_req(FN_INSERT, -32'sd1, 16'd0);
    push_req(FN_INSERT, 32'sd0, 16'hffff);      // clamps to the end
    push_req(FN_INSERT, 32'sd5, 16'd2);
    push_req(FN_SEARCH, 32'sh7fff_ffff, 16'd0);
    push_req(FN_SEARCH, 32'sd12345, 16'd0);
    push_req(FN_UNUSED_FIRST, 32'sh7fff_ffff, 16'hffff);
    push_req(FN_UNUSED_FIRST + 3'd1, -32'sd1, 16'd1);
    push_req(FN_UNUSED_LAST, 32'sd5, 16'd0);
    push_req(FN_RM_AT, 32'sd0, 16'hffff);
    push_req(FN_RM_AT, 32'sd0, 16'd1);
    push_req(FN_RM_VAL, 32'sd5, 16'd0);
    push_req(FN_APPEND, -32'sd1, 16'd0);
    push_req(FN_SEARCH, -32'sd1, 16'd0);       // first of two matches
    push_req(FN_RM_VAL, -32'sd1, 16'd0);
    push_req(FN_RM_AT, 32'sd0, 16'd2);         // last entry
    push_req(FN_RM_VAL, 32'sd99, 16'd0);
    push_req(FN_RM_AT, 32'sd0, 16'd1);
    push_req(FN_RM_AT, 32'sd0, 16'd0);
    wait_drained();

    // fill to capacity, then hit the full case and work on a full list
    for (k = 0; k < LIST_CAP + 2; k++) push_req(FN_APPEND, pick_value(), 16'($urandom));
    push_req(FN_INSERT, pick_value(), 16'd0);
    push_req(FN_SEARCH, list_vals[0], 16'd0);
    push_req(FN_RM_AT, 32'sd0, 16'(LIST_CAP - 1));
    push_req(FN_RM_AT, 32'sd0, 16'(LIST_CAP - 1));
    wait_drained();
    queue_random_requests(440);
    wait_drained();

    // receiver holds off while the sender keeps offering
    hold_req = hold_req + 1;
    queue_random_requests(40);
    wait_drained();

    send_idle_pct = 61;
    queue_random_requests(440);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 61;
    queue_random_requests(440);
    wait_drained();

    send_idle_pct = 36;
    recv_stall_pct = 36;
    queue_random_requests(440);
    wait_drained();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/ole_pkg.sv
design/ole_dp.sv
design/ole_ctrl.sv
design/ordered_list_engine.sv
verif/tb_ordered_list_engine.sv
